FILE: hdl/hotp_pkg.sv
// Shared types and constants for the head orientation to pointer block.
// Used by the channel interfaces, the shared multiplier and the top level.
package hotp_pkg;

  localparam int ACCUM_WIDTH_DEF = 40;

  localparam int ANGLE_W    = 17;
  localparam int DELTA_W    = 18;
  localparam int MOVE_W     = 16;
  localparam int CLICK_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

  localparam logic signed [DELTA_W-1:0] YAW_HALF = 18'sd46080;
  localparam logic signed [DELTA_W-1:0] YAW_FULL = 18'sd92160;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_YAW_GAIN,
    CFG_PITCH_GAIN,
    CFG_DEAD_BAND,
    CFG_SMOOTH_WEIGHT,
    CFG_ROLL_LIMIT,
    CFG_SCROLL_GAIN,
    CFG_INVERT_MASK,
    CFG_TRACKING_ON
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_GX,
    OP_GY,
    OP_GS,
    OP_XC,
    OP_XL,
    OP_XH,
    OP_YC,
    OP_YL,
    OP_YH
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_DEAD,
    S_GX,
    S_GY,
    S_GS,
    S_XC,
    S_XL,
    S_XH,
    S_YC,
    S_YL,
    S_YH,
    S_WAIT,
    S_FRAC,
    S_PIX
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    op_t                       op;
    logic signed [MUL_P_W-1:0] p;
  } mul_rsp_t;

endpackage

FILE: hdl/hotp_in_if.sv
// Input channel of the head orientation to pointer block: one orientation
// sample or recenter request per transaction. Depends on hotp_pkg.
interface hotp_in_if
  import hotp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic signed [ANGLE_W-1:0] pitch_angle;
  logic signed [ANGLE_W-1:0] yaw_angle;

  modport source (output valid, kind, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, kind, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

FILE: hdl/hotp_out_if.sv
// Result channel of the head orientation to pointer block: one pointer move
// and scroll report per transaction. Depends on hotp_pkg.
interface hotp_out_if
  import hotp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [MOVE_W-1:0] move_x;
  logic signed [MOVE_W-1:0] move_y;
  logic [CLICK_W-1:0]       wheel_clicks;
  logic                     scroll_up;

  modport source (output valid, move_x, move_y, wheel_clicks, scroll_up, input ready);
  modport sink   (input valid, move_x, move_y, wheel_clicks, scroll_up, output ready);
endinterface

FILE: hdl/head_orientation_to_pointer.sv
// Top level of the head orientation to pointer block.
// Depends on hotp_pkg, hotp_in_if, hotp_out_if and hotp_mul.
//
// Converts head orientation samples into relative pointer moves and wheel
// clicks. A recenter request, a reference capture, or any transaction while
// tracking is off is handled in the idle state. Every other sample runs from
// acceptance to the result register before the next sample is accepted:
// nine products pass in turn through one shared 36x16 multiplier (two gains,
// the scroll amount and three partial products of each smoothing blend),
// framed by delta, deadzone, accumulate and pixel-extraction steps. The
// final step waits while an earlier result is still held in the output
// register. Configuration writes are taken on any cycle and are expected
// only while the block is idle.
module head_orientation_to_pointer
  import hotp_pkg::*;
#(
  parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hotp_in_if.sink               in_chan,
  hotp_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BW = ACCUM_WIDTH + 20;
  localparam int QW = ACCUM_WIDTH - 16;
  localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN = -Q_MAX;

  // configuration
  logic [15:0] yaw_gain_r, pitch_gain_r, dead_band_r, roll_limit_r, scroll_gain_r;
  logic [8:0]  smooth_weight_r;
  logic [2:0]  invert_mask_r;
  logic        tracking_on_r;

  // control and model state
  state_t state_r, state_nxt;
  logic   ref_valid_r;
  logic   out_valid_r;
  logic signed [ANGLE_W-1:0]     prev_yaw_r, prev_pitch_r;
  logic signed [ACCUM_WIDTH-1:0] prev_dx_r, prev_dy_r, frac_x_r, frac_y_r;

  // working registers
  logic signed [ANGLE_W-1:0]     roll_r, pitch_r, yaw_r;
  logic signed [DELTA_W-1:0]     dyaw_r, dpitch_r, dz_yaw_r, dz_pitch_r;
  logic [DELTA_W-1:0]            scroll_a_r;
  logic signed [MUL_A_W-1:0]     cur_x_r, cur_y_r;
  logic signed [BW-1:0]          blend_r;
  logic signed [ACCUM_WIDTH-1:0] dx_r, dy_r;
  logic [CLICK_W-1:0]            clicks_r;
  logic signed [MOVE_W-1:0]      move_x_r, move_y_r;
  logic [CLICK_W-1:0]            clicks_out_r;
  logic                          up_out_r;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic in_ready, in_acc, start_sample, pix_go;

  hotp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  function automatic logic signed [DELTA_W-1:0] dead_zone(
    input logic signed [DELTA_W-1:0] d,
    input logic [15:0]               db
  );
    logic [DELTA_W-1:0] mag;
    logic [DELTA_W-1:0] m;
    mag = d[DELTA_W-1] ? DELTA_W'(-d) : DELTA_W'(d);
    m   = mag - DELTA_W'(db);
    if (mag < DELTA_W'(db)) begin
      dead_zone = '0;
    end else if (d[DELTA_W-1]) begin
      dead_zone = -$signed(m);
    end else begin
      dead_zone = $signed(m);
    end
  endfunction

  // delta and roll logic
  logic signed [DELTA_W-1:0] dyaw_raw, dyaw_w1, dyaw_w, dpitch_raw;
  logic [DELTA_W-1:0]        roll_abs, roll_ext;
  logic                      roll_over;

  always_comb begin
    dyaw_raw   = DELTA_W'(yaw_r) - DELTA_W'(prev_yaw_r);
    dpitch_raw = DELTA_W'(pitch_r) - DELTA_W'(prev_pitch_r);
    dyaw_w1    = (dyaw_raw > YAW_HALF) ? dyaw_raw - YAW_FULL : dyaw_raw;
    dyaw_w     = (dyaw_w1 < -YAW_HALF) ? dyaw_w1 + YAW_FULL : dyaw_w1;
    roll_ext   = DELTA_W'(roll_r);
    roll_abs   = roll_r[ANGLE_W-1] ? -roll_ext : roll_ext;
    roll_over  = roll_abs > DELTA_W'(roll_limit_r);
  end

  // multiplier operands
  logic [8:0]           w_c, w_inv;
  logic signed [18:0]   ax_ext, ay_ext, ax_sel, ay_sel;

  always_comb begin
    w_c    = (smooth_weight_r > 9'd256) ? 9'd256 : smooth_weight_r;
    w_inv  = 9'd256 - w_c;
    ax_ext = 19'(dz_yaw_r);
    ay_ext = 19'(dz_pitch_r);
    ax_sel = invert_mask_r[0] ? -ax_ext : ax_ext;
    ay_sel = invert_mask_r[1] ? -ay_ext : ay_ext;
  end

  // blend completion and pixel extraction
  logic signed [BW-1:0]          blend_fin;
  logic signed [QW-1:0]          qx, qy;
  logic                          rnd_x, rnd_y;
  logic signed [ACCUM_WIDTH-1:0] rem_x, rem_y;
  logic signed [MOVE_W-1:0]      mx_c, my_c;
  logic                          any_c, up_c;

  always_comb begin
    blend_fin = blend_r + (BW'(mul_rsp.p) <<< 32);
    rnd_x = frac_x_r[ACCUM_WIDTH-1] & (|frac_x_r[15:0]);
    rnd_y = frac_y_r[ACCUM_WIDTH-1] & (|frac_y_r[15:0]);
    qx = $signed(frac_x_r[ACCUM_WIDTH-1:16]) + QW'(rnd_x);
    qy = $signed(frac_y_r[ACCUM_WIDTH-1:16]) + QW'(rnd_y);
    rem_x = {{QW{rnd_x}}, frac_x_r[15:0]};
    rem_y = {{QW{rnd_y}}, frac_y_r[15:0]};
    if (qx > Q_MAX) begin
      mx_c = MOVE_W'(Q_MAX);
    end else if (qx < Q_MIN) begin
      mx_c = MOVE_W'(Q_MIN);
    end else begin
      mx_c = qx[MOVE_W-1:0];
    end
    if (qy > Q_MAX) begin
      my_c = MOVE_W'(Q_MAX);
    end else if (qy < Q_MIN) begin
      my_c = MOVE_W'(Q_MIN);
    end else begin
      my_c = qy[MOVE_W-1:0];
    end
    any_c = (mx_c != '0) || (my_c != '0) || (clicks_r != '0);
    up_c  = (clicks_r != '0) &
            ((!roll_r[ANGLE_W-1] && (roll_r != '0)) ^ invert_mask_r[2]);
  end

  assign in_acc       = in_chan.valid && in_ready;
  assign start_sample = in_acc && tracking_on_r && !in_chan.kind && ref_valid_r;
  assign pix_go       = !out_valid_r || out_chan.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start_sample) state_nxt = S_DELTA;
      S_DELTA: state_nxt = S_DEAD;
      S_DEAD:  state_nxt = S_GX;
      S_GX:    state_nxt = S_GY;
      S_GY:    state_nxt = S_GS;
      S_GS:    state_nxt = S_XC;
      S_XC:    state_nxt = S_XL;
      S_XL:    state_nxt = S_XH;
      S_XH:    state_nxt = S_YC;
      S_YC:    state_nxt = S_YL;
      S_YL:    state_nxt = S_YH;
      S_YH:    state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_FRAC;
      S_FRAC:  state_nxt = S_PIX;
      S_PIX:   if (pix_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier issue
  always_comb begin
    in_ready    = 1'b0;
    mul_req.op  = OP_NONE;
    mul_req.a   = '0;
    mul_req.b   = '0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_GX: begin
        mul_req.op = OP_GX;
        mul_req.a  = MUL_A_W'(ax_sel);
        mul_req.b  = yaw_gain_r;
      end
      S_GY: begin
        mul_req.op = OP_GY;
        mul_req.a  = MUL_A_W'(ay_sel);
        mul_req.b  = pitch_gain_r;
      end
      S_GS: begin
        mul_req.op = OP_GS;
        mul_req.a  = MUL_A_W'({1'b0, scroll_a_r});
        mul_req.b  = scroll_gain_r;
      end
      S_XC: begin
        mul_req.op = OP_XC;
        mul_req.a  = cur_x_r;
        mul_req.b  = MUL_B_W'(w_inv);
      end
      S_XL: begin
        mul_req.op = OP_XL;
        mul_req.a  = MUL_A_W'({1'b0, prev_dx_r[31:0]});
        mul_req.b  = MUL_B_W'(w_c);
      end
      S_XH: begin
        mul_req.op = OP_XH;
        mul_req.a  = MUL_A_W'($signed(prev_dx_r[ACCUM_WIDTH-1:32]));
        mul_req.b  = MUL_B_W'(w_c);
      end
      S_YC: begin
        mul_req.op = OP_YC;
        mul_req.a  = cur_y_r;
        mul_req.b  = MUL_B_W'(w_inv);
      end
      S_YL: begin
        mul_req.op = OP_YL;
        mul_req.a  = MUL_A_W'({1'b0, prev_dy_r[31:0]});
        mul_req.b  = MUL_B_W'(w_c);
      end
      S_YH: begin
        mul_req.op = OP_YH;
        mul_req.a  = MUL_A_W'($signed(prev_dy_r[ACCUM_WIDTH-1:32]));
        mul_req.b  = MUL_B_W'(w_c);
      end
      default: ;
    endcase
  end

  // control, configuration and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      yaw_gain_r      <= 16'd11520;
      pitch_gain_r    <= 16'd11520;
      dead_band_r     <= 16'd0;
      smooth_weight_r <= 9'd0;
      roll_limit_r    <= 16'd5120;
      scroll_gain_r   <= 16'd410;
      invert_mask_r   <= 3'd2;
      tracking_on_r   <= 1'b1;
      ref_valid_r     <= 1'b0;
      out_valid_r     <= 1'b0;
      prev_yaw_r      <= '0;
      prev_pitch_r    <= '0;
      prev_dx_r       <= '0;
      prev_dy_r       <= '0;
      frac_x_r        <= '0;
      frac_y_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_YAW_GAIN:      yaw_gain_r      <= cfg_data;
          CFG_PITCH_GAIN:    pitch_gain_r    <= cfg_data;
          CFG_DEAD_BAND:     dead_band_r     <= cfg_data;
          CFG_SMOOTH_WEIGHT: smooth_weight_r <= cfg_data[8:0];
          CFG_ROLL_LIMIT:    roll_limit_r    <= cfg_data;
          CFG_SCROLL_GAIN:   scroll_gain_r   <= cfg_data;
          CFG_INVERT_MASK:   invert_mask_r   <= cfg_data[2:0];
          CFG_TRACKING_ON:   tracking_on_r   <= cfg_data[0];
          default: ;
        endcase
      end

      // recenter drops the reference; the first sample after it captures one
      if (in_acc && tracking_on_r) begin
        if (in_chan.kind) begin
          ref_valid_r <= 1'b0;
        end else if (!ref_valid_r) begin
          prev_yaw_r   <= in_chan.yaw_angle;
          prev_pitch_r <= in_chan.pitch_angle;
          frac_x_r     <= '0;
          frac_y_r     <= '0;
          ref_valid_r  <= 1'b1;
        end
      end

      if (state_r == S_FRAC) begin
        frac_x_r  <= frac_x_r + dx_r;
        frac_y_r  <= frac_y_r + dy_r;
        prev_dx_r <= dx_r;
        prev_dy_r <= dy_r;
      end

      if (state_r == S_PIX && pix_go) begin
        frac_x_r     <= rem_x;
        frac_y_r     <= rem_y;
        prev_yaw_r   <= yaw_r;
        prev_pitch_r <= pitch_r;
      end

      if (state_r == S_PIX && pix_go && any_c) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start_sample) begin
      roll_r  <= in_chan.roll_angle;
      pitch_r <= in_chan.pitch_angle;
      yaw_r   <= in_chan.yaw_angle;
    end

    if (state_r == S_DELTA) begin
      dyaw_r     <= dyaw_w;
      dpitch_r   <= dpitch_raw;
      scroll_a_r <= roll_over ? roll_abs - DELTA_W'(roll_limit_r) : '0;
    end

    if (state_r == S_DEAD) begin
      dz_yaw_r   <= dead_zone(dyaw_r, dead_band_r);
      dz_pitch_r <= dead_zone(dpitch_r, dead_band_r);
    end

    // take each product as it leaves the multiplier
    case (mul_rsp.op)
      OP_GX: cur_x_r <= mul_rsp.p[MUL_A_W-1:0];
      OP_GY: cur_y_r <= mul_rsp.p[MUL_A_W-1:0];
      OP_GS: clicks_r <= (|mul_rsp.p[MUL_P_W-1:28]) ? 8'hFF : mul_rsp.p[27:20];
      OP_XC, OP_YC: blend_r <= BW'(mul_rsp.p);
      OP_XL, OP_YL: blend_r <= blend_r + BW'(mul_rsp.p);
      OP_XH: dx_r <= blend_fin[ACCUM_WIDTH+7:8];
      OP_YH: dy_r <= blend_fin[ACCUM_WIDTH+7:8];
      default: ;
    endcase

    if (state_r == S_PIX && pix_go && any_c) begin
      move_x_r     <= mx_c;
      move_y_r     <= my_c;
      clicks_out_r <= clicks_r;
      up_out_r     <= up_c;
    end
  end

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.move_x       = move_x_r;
  assign out_chan.move_y       = move_y_r;
  assign out_chan.wheel_clicks = clicks_out_r;
  assign out_chan.scroll_up    = up_out_r;

  a_result_from_pix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_PIX)
    else $error("result raised outside the pixel step");

  a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (move_x_r != '0 || move_y_r != '0 || clicks_out_r != '0))
    else $error("empty result presented");

  a_up_needs_clicks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && up_out_r |-> clicks_out_r != '0)
    else $error("scroll direction set without clicks");

  a_gain_x_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GY |-> mul_rsp.op == OP_GX)
    else $error("multiplier response out of sequence");

endmodule

FILE: hdl/hotp_mul.sv
// Shared signed-by-unsigned multiplier with a registered product and tag.
// Depends on hotp_pkg for the request and response structs.
module hotp_mul
  import hotp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  op_t                       op_r;
  logic signed [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_NONE;
    end else begin
      op_r <= req.op;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= $signed(req.a) * $signed({1'b0, req.b});
  end

  assign rsp.op = op_r;
  assign rsp.p  = p_r;

endmodule

FILE: tb/hotp_tb_pkg.sv
// Item kinds and the result record shared by the pointer testbench files.
// Depends on hotp_pkg for the field widths.
package hotp_tb_pkg;
  import hotp_pkg::*;

  typedef enum logic {
    KIND_SAMPLE,
    KIND_RECENTER
  } item_kind_t;

  typedef struct packed {
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
    logic [CLICK_W-1:0]       wheel_clicks;
    logic                     scroll_up;
  } pointer_report_t;

endpackage

FILE: tb/pointer_report_check.sv
// Watches the sample, report and register ports of the pointer block, predicts
// each report from its own copy of the block state and compares in order.
// Depends on hotp_pkg, hotp_tb_pkg and the two channel interfaces.
module pointer_report_check (
  input  logic                  clk,
  input  logic                  rst_n,
  hotp_in_if                    in_mon,
  hotp_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  output int                    fail_count,
  output int                    pending_reports
);
  timeunit 1ns;
  timeprecision 1ps;
  import hotp_pkg::*;
  import hotp_tb_pkg::*;

  localparam int ACC_W = ACCUM_WIDTH_DEF;

  // register copies
  int   gain_yaw, gain_pitch, dead_band, smooth_w, roll_limit, scroll_gain;
  logic [2:0] invert;
  logic       track_en;

  // pose reference and motion state
  bit     have_ref;
  longint ref_yaw, ref_pitch;
  longint motion_x, motion_y, subpix_x, subpix_y;

  pointer_report_t awaited_reports[$];

  function automatic longint fold_accum(longint v);
    logic signed [ACC_W-1:0] t;
    t = v[ACC_W-1:0];
    return longint'(t);
  endfunction

  function automatic longint apply_deadzone(longint d);
    longint m;
    m = (d < 0) ? -d : d;
    if (m < dead_band) return 0;
    m = m - dead_band;
    return (d > 0) ? m : -m;
  endfunction

  // blend with previous motion, rounding toward minus infinity
  function automatic longint blend_motion(longint cur, longint prev);
    longint w, num;
    w = (smooth_w > 256) ? 256 : smooth_w;
    num = cur * (256 - w) + prev * w;
    return num >>> 8;
  endfunction

  function automatic int take_pixels(inout longint acc);
    longint q;
    q = acc / 65536;
    acc = fold_accum(acc - q * 65536);
    if (q > 32767) q = 32767;
    if (q < -32767) q = -32767;
    return int'(q);
  endfunction

  function automatic bit predict_pointer_report(input item_kind_t kind,
                                                input logic signed [ANGLE_W-1:0] roll,
                                                input logic signed [ANGLE_W-1:0] pitch,
                                                input logic signed [ANGLE_W-1:0] yaw,
                                                output pointer_report_t rep);
    longint d_yaw, d_pitch, dx, dy, a_roll, amt, c;
    int mx, my, clicks;
    logic up;
    rep = '0;
    if (!track_en) return 0;
    if (kind == KIND_RECENTER) begin
      have_ref = 0;
      return 0;
    end
    if (!have_ref) begin
      ref_yaw = yaw;
      ref_pitch = pitch;
      subpix_x = 0;
      subpix_y = 0;
      have_ref = 1;
      return 0;
    end
    d_yaw = longint'(yaw) - ref_yaw;
    d_pitch = longint'(pitch) - ref_pitch;
    if (d_yaw > 46080) d_yaw -= 92160;
    if (d_yaw < -46080) d_yaw += 92160;
    d_yaw = apply_deadzone(d_yaw);
    d_pitch = apply_deadzone(d_pitch);
    dx = d_yaw * gain_yaw;
    dy = d_pitch * gain_pitch;
    if (invert[0]) dx = -dx;
    if (invert[1]) dy = -dy;
    dx = fold_accum(blend_motion(dx, motion_x));
    dy = fold_accum(blend_motion(dy, motion_y));
    subpix_x = fold_accum(subpix_x + dx);
    subpix_y = fold_accum(subpix_y + dy);
    mx = take_pixels(subpix_x);
    my = take_pixels(subpix_y);
    clicks = 0;
    up = 1'b0;
    a_roll = (roll < 0) ? -longint'(roll) : longint'(roll);
    if (a_roll > roll_limit) begin
      amt = (a_roll - roll_limit) * scroll_gain;
      c = amt >>> 20;
      clicks = (c > 255) ? 255 : int'(c);
      if (clicks > 0) begin
        up = (roll > 0);
        if (invert[2]) up = !up;
      end
    end
    ref_yaw = yaw;
    ref_pitch = pitch;
    motion_x = dx;
    motion_y = dy;
    if (mx == 0 && my == 0 && clicks == 0) return 0;
    rep.move_x = mx[MOVE_W-1:0];
    rep.move_y = my[MOVE_W-1:0];
    rep.wheel_clicks = clicks[CLICK_W-1:0];
    rep.scroll_up = up;
    return 1;
  endfunction

  always @(posedge clk) begin : monitor
    pointer_report_t rep;
    pointer_report_t want;
    if (!rst_n) begin
      gain_yaw = 11520;
      gain_pitch = 11520;
      dead_band = 0;
      smooth_w = 0;
      roll_limit = 5120;
      scroll_gain = 410;
      invert = 3'd2;
      track_en = 1'b1;
      have_ref = 0;
      ref_yaw = 0;
      ref_pitch = 0;
      motion_x = 0;
      motion_y = 0;
      subpix_x = 0;
      subpix_y = 0;
      awaited_reports.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_reports.size() == 0) begin
          $error("unexpected report: move_x %0d move_y %0d wheel_clicks %0d scroll_up %0d",
                 out_mon.move_x, out_mon.move_y, out_mon.wheel_clicks, out_mon.scroll_up);
          fail_count++;
        end else begin
          want = awaited_reports.pop_front();
          if (out_mon.move_x !== want.move_x) begin
            $error("move_x: expected %0d, got %0d", want.move_x, out_mon.move_x);
            fail_count++;
          end
          if (out_mon.move_y !== want.move_y) begin
            $error("move_y: expected %0d, got %0d", want.move_y, out_mon.move_y);
            fail_count++;
          end
          if (out_mon.wheel_clicks !== want.wheel_clicks) begin
            $error("wheel_clicks: expected %0d, got %0d", want.wheel_clicks,
                   out_mon.wheel_clicks);
            fail_count++;
          end
          if (out_mon.scroll_up !== want.scroll_up) begin
            $error("scroll_up: expected %0d, got %0d", want.scroll_up, out_mon.scroll_up);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_YAW_GAIN:      gain_yaw = cfg_data;
          CFG_PITCH_GAIN:    gain_pitch = cfg_data;
          CFG_DEAD_BAND:     dead_band = cfg_data;
          CFG_SMOOTH_WEIGHT: smooth_w = cfg_data[8:0];
          CFG_ROLL_LIMIT:    roll_limit = cfg_data;
          CFG_SCROLL_GAIN:   scroll_gain = cfg_data;
          CFG_INVERT_MASK:   invert = cfg_data[2:0];
          CFG_TRACKING_ON:   track_en = cfg_data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (predict_pointer_report(item_kind_t'(in_mon.kind), in_mon.roll_angle,
                                   in_mon.pitch_angle, in_mon.yaw_angle, rep))
          awaited_reports.push_back(rep);
      end
    end
    pending_reports = awaited_reports.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the pointer block testbench: clock, reset, register writes and
// sample stimulus with random idling, plus the watchdog and the verdict.
// Depends on hotp_pkg, hotp_tb_pkg, the channel interfaces and pointer_report_check.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hotp_pkg::*;
  import hotp_tb_pkg::*;

  localparam int SETTLE_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 50;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count;
  int pending_reports;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int head_yaw = 0;
  int head_pitch = 0;

  hotp_in_if  in_chan();
  hotp_out_if out_chan();

  head_orientation_to_pointer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pointer_report_check report_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_reports (pending_reports)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // count cycles without any transaction or register write
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic drive_item(item_kind_t kind, int roll, int pitch, int yaw);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.kind        <= kind;
    in_chan.roll_angle  <= roll[ANGLE_W-1:0];
    in_chan.pitch_angle <= pitch[ANGLE_W-1:0];
    in_chan.yaw_angle   <= yaw[ANGLE_W-1:0];
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender until every report is in, then let a dropped sample finish
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending_reports != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all_regs(int yaw_g, int pitch_g, int band, int smooth, int limit,
                                int scroll_g, int inv, int track);
    write_reg(CFG_YAW_GAIN, yaw_g);
    write_reg(CFG_PITCH_GAIN, pitch_g);
    write_reg(CFG_DEAD_BAND, band);
    write_reg(CFG_SMOOTH_WEIGHT, smooth);
    write_reg(CFG_ROLL_LIMIT, limit);
    write_reg(CFG_SCROLL_GAIN, scroll_g);
    write_reg(CFG_INVERT_MASK, inv);
    write_reg(CFG_TRACKING_ON, track);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    int r;
    int step;
    int roll;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_chan.valid       = 1'b0;
    in_chan.kind        = 1'b0;
    in_chan.roll_angle  = '0;
    in_chan.pitch_angle = '0;
    in_chan.yaw_angle   = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: capture, moves, scrolling both ways, roll at the limit
    drive_item(KIND_SAMPLE, 0, 0, 0);
    drive_item(KIND_SAMPLE, 0, 0, 512);
    drive_item(KIND_SAMPLE, 0, -768, 512);
    drive_item(KIND_SAMPLE, 46080, -768, 512);
    drive_item(KIND_SAMPLE, -46080, -768, 512);
    drive_item(KIND_SAMPLE, 5120, -768, 512);
    drive_item(KIND_SAMPLE, 5121, -768, 512);
    // yaw wrap across the back in both directions
    drive_item(KIND_SAMPLE, 0, -768, 46080);
    drive_item(KIND_SAMPLE, 0, -768, -46080);
    drive_item(KIND_SAMPLE, 0, -768, 46079);
    // raw field extremes beyond the angle range
    drive_item(KIND_SAMPLE, -65536, 65535, -65536);
    drive_item(KIND_SAMPLE, 65535, -65536, 65535);
    drive_item(KIND_RECENTER, 0, 0, 0);
    drive_item(KIND_SAMPLE, 0, 100, 100);
    drive_item(KIND_SAMPLE, 0, 100, 100);
    settle();

    // full gains for saturation, weight above one, every inversion
    write_all_regs(65535, 65535, 256, 511, 0, 65535, 7, 1);
    drive_item(KIND_SAMPLE, 0, 40100, 40100);
    drive_item(KIND_SAMPLE, -46080, 40100, 40100);
    drive_item(KIND_SAMPLE, 1, 0, 0);
    drive_item(KIND_SAMPLE, 0, -65536, 65535);
    settle();

    // tracking off drops everything, recenter included
    write_all_regs(11520, 11520, 0, 0, 5120, 410, 2, 0);
    drive_item(KIND_RECENTER, 0, 0, 0);
    drive_item(KIND_SAMPLE, 46080, 9000, -9000);
    drive_item(KIND_SAMPLE, -46080, -9000, 9000);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: write_all_regs(65535, 65535, 46080, 256, 46080, 65535, 7, 1);
        1: write_all_regs(0, 0, 0, 0, 0, 0, 0, 1);
        default: write_all_regs(
            ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 16384),
            ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 16384),
            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 256),
            ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256),
            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 46080),
            $urandom_range(0, 65535),
            $urandom_range(0, 7),
            ($urandom_range(0, 9) != 0));
      endcase
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 50; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 50; end
        default: begin send_gap_pct = 9; stall_pct = 9; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          drive_item(KIND_RECENTER, $urandom(), $urandom(), $urandom());
        end else if (r < 10) begin
          drive_item(KIND_SAMPLE, $urandom(), $urandom(), $urandom());
        end else begin
          // walk the head pose, with the odd fast turn
          step = ($urandom_range(0, 19) == 0) ? 8192 : 768;
          head_yaw += int'($urandom_range(0, 2 * step)) - step;
          if (head_yaw > 46080) head_yaw -= 92160;
          if (head_yaw < -46080) head_yaw += 92160;
          head_pitch += int'($urandom_range(0, 2 * step)) - step;
          if (head_pitch > 46080) head_pitch = 46080;
          if (head_pitch < -46080) head_pitch = -46080;
          if (r < 60)
            roll = int'($urandom_range(0, 2048)) - 1024;
          else
            roll = int'($urandom_range(0, 92160)) - 46080;
          drive_item(KIND_SAMPLE, roll, head_pitch, head_yaw);
        end
      end
    end

    settle();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
